[src/rcfd_pkg.sv]
package rcfd_pkg;

  // Bytes of the frame protocol.
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CH_EIGHT  = 8'h38;  // '8'
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CTRL1  = 8'h01;
  localparam logic [7:0] CH_CTRL8  = 8'h08;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Speeds in thousandths of mm per second.
  localparam logic [18:0] SPEED_RESET = 19'd200000;
  localparam logic [18:0] SPEED_MAX   = 19'd400000;
  localparam logic [18:0] STEP_MIN    = 19'd100000;
  localparam logic [18:0] STEP_SIZE   = 19'd50000;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;

  typedef enum logic [3:0] {
    PH_LEAD = 4'b0001,
    PH_INT  = 4'b0010,
    PH_FRAC = 4'b0100,
    PH_DONE = 4'b1000
  } num_phase_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_GAIN  = 2'd1,
    ACT_START = 2'd2,
    ACT_STOP  = 2'd3
  } action_e;

  typedef struct packed {
    num_phase_e  phase;
    logic        negative;
    logic [1:0]  frac_digits;
    logic [31:0] magnitude;
  } num_state_t;

  typedef struct packed {
    logic       in_frame;
    logic       suffix_pending;
    logic       stream_flag;
    logic       remote_flag;
    logic       text_ended;
    logic       colon_ok;
    logic       p_seen;
    logic [7:0] first_char;
  } frame_flags_t;

  typedef struct packed {
    logic               consumed;
    action_e            action;
    logic               report;
    logic [1:0]         gain_slot;
    logic signed [31:0] gain_value;
    logic [18:0]        target_speed;
    logic               stream_on;
  } result_t;

  // Weight of the next fraction digit in thousandths.
  function automatic logic [6:0] frac_weight(input logic [1:0] idx);
    logic [6:0] w;
    unique case (idx)
      2'd0:    w = 7'd100;
      2'd1:    w = 7'd10;
      default: w = 7'd1;
    endcase
    return w;
  endfunction

endpackage

[src/remote_command_frame_decoder_unit.sv]
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  command, data_byte, task_busy, follow_active
// out      output     out_valid_o/out_stall_i consumed, action, report, gain_slot,
//                                            gain_value, target_speed, stream_on
//
// One item per cycle while the output is not stalled; an item's result is offered once it has
// passed the input register and then the decode into the result register and the frame state.
// The decode of one byte, including the digit multiply-add, is combinational.
// Reset clears the frame state and sets the target speed to 200000.
// A stalled result holds the pipeline; the input register still takes one item.
module remote_command_frame_decoder_unit #(
  parameter int FRAME_LIMIT = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [7:0]         data_byte_i,
  input  logic               task_busy_i,
  input  logic               follow_active_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               consumed_o,
  output logic [1:0]         action_o,
  output logic               report_o,
  output logic [1:0]         gain_slot_o,
  output logic signed [31:0] gain_value_o,
  output logic [18:0]        target_speed_o,
  output logic               stream_on_o
);
  import rcfd_pkg::*;

  localparam int CntW = $clog2(FRAME_LIMIT);

  logic         in_valid_q;
  logic         command_q;
  logic [7:0]   char_q;
  logic         busy_q;
  logic         active_q;

  frame_flags_t flags_q, flags_d;
  logic [CntW-1:0] count_q, count_d;
  num_state_t   num_q, num_d;
  logic [18:0]  speed_q, speed_d;
  result_t      result_d, result_q;
  logic         out_valid_q;

  logic         advance;
  logic         take_in;

  // The decode stage moves on when the result register is free or being emptied.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || advance) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      command_q <= command_i;
      char_q    <= data_byte_i;
      busy_q    <= task_busy_i;
      active_q  <= follow_active_i;
    end
  end

  rcfd_frame #(
    .FRAME_LIMIT (FRAME_LIMIT),
    .CntW        (CntW)
  ) u_frame (
    .command_i       (command_q),
    .char_i          (char_q),
    .task_busy_i     (busy_q),
    .follow_active_i (active_q),
    .flags_i         (flags_q),
    .count_i         (count_q),
    .num_i           (num_q),
    .speed_i         (speed_q),
    .flags_o         (flags_d),
    .count_o         (count_d),
    .num_o           (num_d),
    .speed_o         (speed_d),
    .result_o        (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      count_q     <= '0;
      num_q       <= '{phase: PH_LEAD, negative: 1'b0, frac_digits: 2'd0, magnitude: 32'd0};
      speed_q     <= SPEED_RESET;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        flags_q <= flags_d;
        count_q <= count_d;
        num_q   <= num_d;
        speed_q <= speed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign consumed_o     = result_q.consumed;
  assign action_o       = result_q.action;
  assign report_o       = result_q.report;
  assign gain_slot_o    = result_q.gain_slot;
  assign gain_value_o   = result_q.gain_value;
  assign target_speed_o = result_q.target_speed;
  assign stream_on_o    = result_q.stream_on;

endmodule

[src/rcfd_number.sv]
module rcfd_number (
  input  rcfd_pkg::num_state_t cur_i,
  input  logic [7:0]           char_i,
  output rcfd_pkg::num_state_t nxt_o
);
  import rcfd_pkg::*;

  logic        is_digit;
  logic        is_space;
  logic [3:0]  digit;
  logic [35:0] int_sum;
  logic [31:0] int_mag;
  logic [32:0] frac_sum;
  logic [31:0] frac_mag;

  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_space = (char_i == CH_SPACE) || ((char_i >= CH_TAB) && (char_i <= CH_CR));
  assign digit    = 4'(char_i - CH_ZERO);

  // Integer digit: magnitude * 10 + digit * 1000, saturating at 2^31.
  assign int_sum  = ({4'd0, cur_i.magnitude} << 3) + ({4'd0, cur_i.magnitude} << 1)
                  + 36'(digit) * 36'd1000;
  assign int_mag  = (int_sum > {4'd0, MAG_CAP}) ? MAG_CAP : int_sum[31:0];
  assign frac_sum = {1'b0, cur_i.magnitude}
                  + 33'(digit) * 33'(frac_weight(cur_i.frac_digits));
  assign frac_mag = (frac_sum > {1'b0, MAG_CAP}) ? MAG_CAP : frac_sum[31:0];

  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.phase)
      PH_LEAD: begin
        if (is_space) begin
          nxt_o = cur_i;
        end else if (char_i == CH_PLUS || char_i == CH_MINUS) begin
          nxt_o.negative = (char_i == CH_MINUS);
          nxt_o.phase    = PH_INT;
        end else if (is_digit) begin
          nxt_o.magnitude = int_mag;
          nxt_o.phase     = PH_INT;
        end else if (char_i == CH_DOT) begin
          nxt_o.phase = PH_FRAC;
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          nxt_o.magnitude = int_mag;
        end else if (char_i == CH_DOT) begin
          nxt_o.phase = PH_FRAC;
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          // Digits past the third are dropped.
          if (cur_i.frac_digits != 2'd3) begin
            nxt_o.magnitude   = frac_mag;
            nxt_o.frac_digits = cur_i.frac_digits + 2'd1;
          end
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
      PH_DONE: nxt_o.phase = PH_DONE;
      default: nxt_o = cur_i;
    endcase
  end

endmodule

[src/rcfd_frame.sv]
module rcfd_frame #(
  parameter int FRAME_LIMIT = 32,
  parameter int CntW        = $clog2(FRAME_LIMIT)
) (
  input  logic                   command_i,
  input  logic [7:0]             char_i,
  input  logic                   task_busy_i,
  input  logic                   follow_active_i,
  input  rcfd_pkg::frame_flags_t flags_i,
  input  logic [CntW-1:0]        count_i,
  input  rcfd_pkg::num_state_t   num_i,
  input  logic [18:0]            speed_i,
  output rcfd_pkg::frame_flags_t flags_o,
  output logic [CntW-1:0]        count_o,
  output rcfd_pkg::num_state_t   num_o,
  output logic [18:0]            speed_o,
  output rcfd_pkg::result_t      result_o
);
  import rcfd_pkg::*;

  localparam logic [CntW-1:0] CountLast = CntW'(FRAME_LIMIT - 1);

  num_state_t         num_fed;
  logic signed [31:0] value;
  logic [18:0]        value_clamped;
  logic signed [20:0] speed_up;
  logic signed [20:0] speed_down;
  logic [18:0]        speed_up_cl;
  logic [18:0]        speed_down_cl;
  logic               is_remote_key;
  logic [7:0]         slot_char;

  rcfd_number u_number (
    .cur_i  (num_i),
    .char_i (char_i),
    .nxt_o  (num_fed)
  );

  // Frame value; a negative magnitude of 2^31 wraps to the most negative value.
  always_comb begin
    if (num_i.negative) begin
      value = signed'(32'd0 - num_i.magnitude);
    end else if (num_i.magnitude >= MAG_CAP) begin
      value = 32'sh7FFF_FFFF;
    end else begin
      value = signed'(num_i.magnitude);
    end
  end

  always_comb begin
    if (value < 0) begin
      value_clamped = 19'd0;
    end else if (value > signed'({13'd0, SPEED_MAX})) begin
      value_clamped = SPEED_MAX;
    end else begin
      value_clamped = value[18:0];
    end
  end

  assign speed_up   = signed'({2'b00, speed_i}) + signed'({2'b00, STEP_SIZE});
  assign speed_down = signed'({2'b00, speed_i}) - signed'({2'b00, STEP_SIZE});

  always_comb begin
    if (speed_up > signed'({2'b00, SPEED_MAX})) begin
      speed_up_cl = SPEED_MAX;
    end else if (speed_up < signed'({2'b00, STEP_MIN})) begin
      speed_up_cl = STEP_MIN;
    end else begin
      speed_up_cl = speed_up[18:0];
    end
    if (speed_down < signed'({2'b00, STEP_MIN})) begin
      speed_down_cl = STEP_MIN;
    end else if (speed_down > signed'({2'b00, SPEED_MAX})) begin
      speed_down_cl = SPEED_MAX;
    end else begin
      speed_down_cl = speed_down[18:0];
    end
  end

  assign is_remote_key = (char_i <= CH_CTRL8) || ((char_i >= CH_A) && (char_i <= CH_H))
                       || (char_i == CH_X) || (char_i == CH_Y);
  assign slot_char     = flags_i.first_char - CH_ZERO;

  always_comb begin
    flags_o = flags_i;
    count_o = count_i;
    num_o   = num_i;
    speed_o = speed_i;
    result_o.consumed   = 1'b0;
    result_o.action     = ACT_NONE;
    result_o.report     = 1'b0;
    result_o.gain_slot  = 2'd0;
    result_o.gain_value = 32'sd0;

    if (command_i) begin
      if (!task_busy_i) begin
        result_o.action = follow_active_i ? ACT_STOP : ACT_START;
      end
    end else if (char_i == CH_LBRACE) begin
      // A new frame starts even inside an open one.
      count_o                = '0;
      flags_o.text_ended     = 1'b0;
      flags_o.first_char     = CH_NUL;
      flags_o.colon_ok       = 1'b0;
      flags_o.p_seen         = 1'b0;
      num_o                  = '0;
      num_o.phase            = PH_LEAD;
      flags_o.in_frame       = 1'b1;
      flags_o.suffix_pending = 1'b0;
      flags_o.stream_flag    = 1'b1;
      result_o.consumed      = 1'b1;
    end else if (flags_i.in_frame) begin
      result_o.consumed = 1'b1;
      if (char_i == CH_RBRACE) begin
        flags_o.in_frame       = 1'b0;
        flags_o.suffix_pending = 1'b1;
        if (flags_i.first_char == CH_C && flags_i.p_seen) begin
          result_o.report = 1'b1;
        end else if (count_i >= CntW'(3) && flags_i.first_char >= CH_ZERO
                     && flags_i.first_char <= CH_EIGHT && flags_i.colon_ok) begin
          if (slot_char <= 8'd2) begin
            result_o.action     = ACT_GAIN;
            result_o.gain_slot  = slot_char[1:0];
            result_o.gain_value = value;
            result_o.report     = 1'b1;
          end else if (slot_char == 8'd3) begin
            speed_o         = value_clamped;
            result_o.report = 1'b1;
          end
        end
      end else if (count_i < CountLast) begin
        if (count_i == '0) begin
          flags_o.first_char = char_i;
        end
        if (count_i == CntW'(1)) begin
          flags_o.colon_ok = (char_i == CH_COLON);
        end
        // After a zero byte the text has ended; bytes still count toward the length.
        if (!flags_i.text_ended) begin
          if (char_i == CH_NUL) begin
            flags_o.text_ended = 1'b1;
          end else begin
            if (char_i == CH_P) begin
              flags_o.p_seen = 1'b1;
            end
            if (count_i >= CntW'(2)) begin
              num_o = num_fed;
            end
          end
        end
        count_o = count_i + CntW'(1);
      end else begin
        // Length limit reached: the frame is dropped.
        count_o          = '0;
        flags_o.in_frame = 1'b0;
      end
    end else if (flags_i.suffix_pending && char_i == CH_DOLLAR) begin
      flags_o.suffix_pending = 1'b0;
      result_o.consumed      = 1'b1;
    end else begin
      flags_o.suffix_pending = 1'b0;
      if (char_i == CH_I || char_i == CH_J || char_i == CH_K) begin
        flags_o.remote_flag = 1'b1;
        flags_o.stream_flag = 1'b1;
        result_o.consumed   = 1'b1;
      end else if (flags_i.remote_flag && is_remote_key) begin
        result_o.consumed = 1'b1;
        if (!task_busy_i) begin
          if (char_i == CH_A || char_i == CH_CTRL1) begin
            if (!follow_active_i) begin
              result_o.action = ACT_START;
            end
          end else if (char_i == CH_X) begin
            speed_o         = speed_up_cl;
            result_o.report = 1'b1;
          end else if (char_i == CH_Y) begin
            speed_o         = speed_down_cl;
            result_o.report = 1'b1;
          end else begin
            result_o.action = ACT_STOP;
          end
        end
      end
    end

    result_o.target_speed = speed_o;
    result_o.stream_on    = flags_o.stream_flag;
  end

endmodule

[tb/remote_command_frame_decoder_unit_test.sv]
`timescale 1ns / 1ps

module remote_command_frame_decoder_unit_test;
  import rcfd_pkg::*;

  localparam int FRAME_LIMIT = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 280;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = 1'b0;
  logic [7:0]         data_byte_i = 8'h00;
  logic               task_busy_i = 1'b0;
  logic               follow_active_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               consumed_o;
  logic [1:0]         action_o;
  logic               report_o;
  logic [1:0]         gain_slot_o;
  logic signed [31:0] gain_value_o;
  logic [18:0]        target_speed_o;
  logic               stream_on_o;

  remote_command_frame_decoder_unit #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .command_i(command_i),
    .data_byte_i(data_byte_i),
    .task_busy_i(task_busy_i),
    .follow_active_i(follow_active_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .consumed_o(consumed_o),
    .action_o(action_o),
    .report_o(report_o),
    .gain_slot_o(gain_slot_o),
    .gain_value_o(gain_value_o),
    .target_speed_o(target_speed_o),
    .stream_on_o(stream_on_o)
  );

  always #5 clk_i = ~clk_i;

  result_t expected_q[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      items_sent = 0;
  logic    idle_off = 1'b0;
  logic    hold_request = 1'b0;
  int      stall_left = 0;

  // Decoder state as the predictor sees it.
  logic       in_frame_m, suffix_m, stream_m, remote_m, text_end_m, colon_m, pseen_m;
  logic [7:0] first_m;
  int         count_m;
  num_phase_e phase_m;
  logic       neg_m;
  logic [1:0] fdig_m;
  logic [31:0] mag_m;
  logic [18:0] speed_m;

  function automatic void clear_frame_model();
    count_m = 0;
    text_end_m = 1'b0;
    first_m = 8'h00;
    colon_m = 1'b0;
    pseen_m = 1'b0;
    phase_m = PH_LEAD;
    neg_m = 1'b0;
    fdig_m = 2'd0;
    mag_m = 32'd0;
  endfunction

  function automatic void reset_model();
    in_frame_m = 1'b0;
    suffix_m = 1'b0;
    stream_m = 1'b0;
    remote_m = 1'b0;
    clear_frame_model();
    speed_m = SPEED_RESET;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  // One byte of the number text; the magnitude saturates at 2^31.
  function automatic void feed_number_model(input logic [7:0] ch);
    num_phase_e ph;
    logic [63:0] m;
    int weight;
    ph = phase_m;
    if (ph == PH_LEAD) begin
      if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) return;
      if (ch == CH_PLUS || ch == CH_MINUS) begin
        neg_m = (ch == CH_MINUS);
        phase_m = PH_INT;
        return;
      end
      ph = PH_INT;
    end
    case (ph)
      PH_INT: begin
        if (is_digit(ch)) begin
          m = 64'(mag_m) * 10 + 64'(ch - CH_ZERO) * 1000;
          mag_m = (m > 64'(MAG_CAP)) ? MAG_CAP : m[31:0];
          phase_m = PH_INT;
        end else if (ch == CH_DOT) begin
          phase_m = PH_FRAC;
        end else begin
          phase_m = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_digit(ch)) begin
          if (fdig_m < 2'd3) begin
            weight = (fdig_m == 2'd0) ? 100 : ((fdig_m == 2'd1) ? 10 : 1);
            m = 64'(mag_m) + 64'(ch - CH_ZERO) * weight;
            mag_m = (m > 64'(MAG_CAP)) ? MAG_CAP : m[31:0];
            fdig_m = fdig_m + 2'd1;
          end
        end else begin
          phase_m = PH_DONE;
        end
      end
      default: phase_m = PH_DONE;
    endcase
  endfunction

  function automatic void store_byte_model(input logic [7:0] ch);
    if (count_m == 0) first_m = ch;
    if (count_m == 1) colon_m = (ch == CH_COLON);
    if (!text_end_m) begin
      if (ch == CH_NUL) begin
        text_end_m = 1'b1;
      end else begin
        if (ch == CH_P) pseen_m = 1'b1;
        if (count_m >= 2) feed_number_model(ch);
      end
    end
    count_m++;
  endfunction

  function automatic logic signed [31:0] parsed_value();
    if (neg_m) return 32'(32'd0 - mag_m);
    return (mag_m >= MAG_CAP) ? 32'h7FFF_FFFF : mag_m;
  endfunction

  function automatic logic [18:0] clamp_speed(input int v, input int lo);
    if (v < lo) return 19'(lo);
    if (v > int'(SPEED_MAX)) return SPEED_MAX;
    return 19'(v);
  endfunction

  function automatic result_t decode_model(input logic cmd, input logic [7:0] ch,
                                           input logic busy, input logic active);
    result_t r;
    logic [7:0] slot;
    r.consumed = 1'b0;
    r.action = ACT_NONE;
    r.report = 1'b0;
    r.gain_slot = 2'd0;
    r.gain_value = 32'sd0;
    if (cmd) begin
      if (!busy) r.action = active ? ACT_STOP : ACT_START;
    end else if (ch == CH_LBRACE) begin
      clear_frame_model();
      in_frame_m = 1'b1;
      suffix_m = 1'b0;
      stream_m = 1'b1;
      r.consumed = 1'b1;
    end else if (in_frame_m) begin
      r.consumed = 1'b1;
      if (ch == CH_RBRACE) begin
        in_frame_m = 1'b0;
        suffix_m = 1'b1;
        if (first_m == CH_C && pseen_m) begin
          r.report = 1'b1;
        end else if (count_m >= 3 && first_m >= CH_ZERO && first_m <= CH_EIGHT && colon_m) begin
          slot = first_m - CH_ZERO;
          if (slot <= 8'd2) begin
            r.action = ACT_GAIN;
            r.gain_slot = slot[1:0];
            r.gain_value = parsed_value();
            r.report = 1'b1;
          end else if (slot == 8'd3) begin
            speed_m = clamp_speed(int'(parsed_value()), 0);
            r.report = 1'b1;
          end
        end
      end else if (count_m < FRAME_LIMIT - 1) begin
        store_byte_model(ch);
      end else begin
        // Too long: the frame is dropped, the byte still belongs to it.
        count_m = 0;
        in_frame_m = 1'b0;
      end
    end else if (suffix_m && ch == CH_DOLLAR) begin
      suffix_m = 1'b0;
      r.consumed = 1'b1;
    end else begin
      suffix_m = 1'b0;
      if (ch == CH_I || ch == CH_J || ch == CH_K) begin
        remote_m = 1'b1;
        stream_m = 1'b1;
        r.consumed = 1'b1;
      end else if (remote_m && (ch <= CH_CTRL8 || (ch >= CH_A && ch <= CH_H) ||
                                ch == CH_X || ch == CH_Y)) begin
        r.consumed = 1'b1;
        if (!busy) begin
          if (ch == CH_A || ch == CH_CTRL1) begin
            if (!active) r.action = ACT_START;
          end else if (ch == CH_X) begin
            speed_m = clamp_speed(int'(speed_m) + int'(STEP_SIZE), int'(STEP_MIN));
            r.report = 1'b1;
          end else if (ch == CH_Y) begin
            speed_m = clamp_speed(int'(speed_m) - int'(STEP_SIZE), int'(STEP_MIN));
            r.report = 1'b1;
          end else begin
            r.action = ACT_STOP;
          end
        end
      end
    end
    r.target_speed = speed_m;
    r.stream_on = stream_m;
    return r;
  endfunction

  function automatic int pick_idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_gap();
    if (idle_off || $urandom_range(0, 99) < 70) return 0;
    return pick_idle_len();
  endfunction

  // Offers one item and records its expected result once it is taken.
  task automatic send_item(input logic cmd, input logic [7:0] ch,
                           input logic busy, input logic active);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    data_byte_i <= ch;
    task_busy_i <= busy;
    follow_active_i <= active;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(decode_model(cmd, ch, busy, active));
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_item(1'b0, ch, $urandom_range(0, 3) == 0, $urandom_range(0, 1));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] pick_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_remote_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 8));
      1: return 8'(CH_A + $urandom_range(0, 7));
      2: return CH_X;
      default: return CH_Y;
    endcase
  endfunction

  // A random byte that neither opens nor closes a frame.
  function automatic logic [7:0] pick_filler();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    if (ch == CH_LBRACE || ch == CH_RBRACE) ch = CH_P;
    return ch;
  endfunction

  task automatic send_number_frame();
    int n;
    send_char(CH_LBRACE);
    send_char(($urandom_range(0, 99) < 85) ? 8'(CH_ZERO + $urandom_range(0, 8)) : pick_filler());
    send_char(($urandom_range(0, 9) != 0) ? CH_COLON : pick_filler());
    repeat ($urandom_range(0, 2))
      send_char(($urandom_range(0, 5) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4)));
    case ($urandom_range(0, 2))
      1: send_char(CH_PLUS);
      2: send_char(CH_MINUS);
      default: ;
    endcase
    n = $urandom_range(0, 9);
    if (n < 7) n = $urandom_range(0, 4);
    else if (n < 9) n = $urandom_range(5, 7);
    else n = $urandom_range(9, 12);
    repeat (n) send_char(pick_digit());
    if ($urandom_range(0, 9) < 6) begin
      send_char(CH_DOT);
      repeat ($urandom_range(0, 5)) send_char(pick_digit());
    end
    case ($urandom_range(0, 9))
      0: begin
        send_char(CH_NUL);
        send_char(pick_digit());
      end
      1: begin
        send_char(pick_filler());
        send_char(pick_digit());
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) != 0) send_char(CH_RBRACE);
    if ($urandom_range(0, 1) != 0) send_char(CH_DOLLAR);
  endtask

  task automatic send_report_frame();
    send_char(CH_LBRACE);
    send_char(($urandom_range(0, 9) != 0) ? CH_C : pick_filler());
    repeat ($urandom_range(0, 5)) send_char(pick_filler());
    if ($urandom_range(0, 6) == 0) send_char(CH_NUL);
    if ($urandom_range(0, 9) < 7) send_char(CH_P);
    repeat ($urandom_range(0, 2)) send_char(pick_filler());
    send_char(CH_RBRACE);
    if ($urandom_range(0, 1) != 0) send_char(CH_DOLLAR);
  endtask

  task automatic send_long_frame();
    send_char(CH_LBRACE);
    send_char(8'(CH_ZERO + $urandom_range(0, 3)));
    send_char(CH_COLON);
    repeat ($urandom_range(FRAME_LIMIT - 6, FRAME_LIMIT + 4)) begin
      send_char(($urandom_range(0, 1) != 0) ? pick_digit() : pick_filler());
    end
    send_char(CH_RBRACE);
  endtask

  task automatic send_remote_burst();
    send_char(8'(CH_I + $urandom_range(0, 2)));
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 7) == 0)
        send_item(1'b1, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 1));
      else
        send_char(pick_remote_byte());
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_item($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)),
                $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  task automatic test_toggle();
    send_item(1'b1, 8'hFF, 1'b0, 1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b1);
    send_item(1'b1, 8'hA5, 1'b1, 1'b0);
    send_item(1'b1, 8'h5A, 1'b1, 1'b1);
  endtask

  task automatic test_remote_controls();
    // A control byte before any remote enable is not ours.
    send_item(1'b0, CH_A, 1'b0, 1'b0);
    send_item(1'b0, CH_I, 1'b0, 1'b0);
    send_item(1'b0, CH_X, 1'b0, 1'b0);
    send_item(1'b0, CH_Y, 1'b0, 1'b0);
    send_item(1'b0, CH_A, 1'b0, 1'b0);
    send_item(1'b0, CH_CTRL1, 1'b0, 1'b1);
    send_item(1'b0, 8'h42, 1'b1, 1'b0);
    send_item(1'b0, CH_NUL, 1'b0, 1'b0);
  endtask

  task automatic test_report_frame();
    send_text("{CP}$");
    send_text("{C");
    send_char(CH_NUL);
    send_text("P}");
  endtask

  task automatic test_gain_frame();
    send_text("{2: -1.2345}");
    // The second open brace restarts the frame.
    send_text("{0{1:7}");
  endtask

  task automatic test_speed_frame();
    send_text("{3:999}");
    send_item(1'b0, CH_Y, 1'b0, 1'b0);
  endtask

  task automatic test_frame_limit();
    send_text("{1:");
    repeat (FRAME_LIMIT - 2) send_char(CH_NINE);
    send_char(CH_RBRACE);
  endtask

  task automatic test_output_backpressure();
    idle_off = 1'b1;
    hold_request <= 1'b1;
    repeat (5) send_number_frame();
    idle_off = 1'b0;
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int next_phase;
    int pick;
    stop_at = items_sent + RANDOM_ITEMS;
    next_phase = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_phase) begin
        idle_off = ($urandom_range(0, 3) == 0);
        next_phase = items_sent + 50;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) send_number_frame();
      else if (pick < 50) send_report_frame();
      else if (pick < 55) send_long_frame();
      else if (pick < 80) send_remote_burst();
      else if (pick < 90) send_noise();
      else send_item(1'b1, 8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                     $urandom_range(0, 1));
    end
    idle_off = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && !idle_off && $urandom_range(0, 99) < 15) begin
      stall_left = pick_idle_len();
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                 name, cycle_count, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result item with none expected at cycle %0d", cycle_count);
      end else begin
        want = expected_q.pop_front();
        check_field("consumed", want.consumed, consumed_o);
        check_field("action", want.action, action_o);
        check_field("report", want.report, report_o);
        check_field("gain_slot", want.gain_slot, gain_slot_o);
        check_field("gain_value", want.gain_value, gain_value_o);
        check_field("target_speed", want.target_speed, target_speed_o);
        check_field("stream_on", want.stream_on, stream_on_o);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** remote_command_frame_decoder_unit: FAILED **");
    $finish;
  end

  initial begin
    reset_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_toggle();
    test_remote_controls();
    test_report_frame();
    test_gain_frame();
    test_speed_frame();
    test_frame_limit();
    test_output_backpressure();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("** remote_command_frame_decoder_unit: PASSED **");
    end else begin
      $display("** remote_command_frame_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
src/rcfd_pkg.sv
src/rcfd_number.sv
src/rcfd_frame.sv
src/remote_command_frame_decoder_unit.sv
tb/remote_command_frame_decoder_unit_test.sv
